// File: hdl/p4sd_pkg.sv
// ----------------------------------------------------------------------------
// p4sd_pkg
// Shared types and constants for the 4bpp palette sprite decoder.
// ----------------------------------------------------------------------------
package p4sd_pkg;

	// Payload widths.
	localparam int DATA_W  = 8;
	localparam int COLOR_W = 16;
	localparam int SIDE_W  = 7;
	localparam int NIBBLE_W = 4;

	// Palette geometry: sixteen big-endian RGB565 entries, two bytes each.
	localparam int PAL_ENTRIES = 16;
	localparam int PAL_IDX_W   = $clog2(PAL_ENTRIES);
	localparam int PAL_BYTES   = 2 * PAL_ENTRIES;

	// Default largest sprite side and reset size.
	localparam int MAX_SIDE_DEF = 64;
	localparam int SIDE_RESET   = 32;

	// Configuration port geometry.
	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 3;

	// Register indexes on the configuration port.
	typedef enum logic [0:0] {
		REG_SPRITE_WIDTH  = 1'b0,
		REG_SPRITE_HEIGHT = 1'b1
	} reg_idx_t;

endpackage

// File: hdl/p4sd_byte_if.sv
// ----------------------------------------------------------------------------
// p4sd_byte_if
// Valid/ready channel that carries one byte of a sprite frame per beat.
// ----------------------------------------------------------------------------
interface p4sd_byte_if;

	logic                         valid;
	logic                         ready;
	logic [p4sd_pkg::DATA_W-1:0]  data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);

endinterface

// File: hdl/p4sd_pix_if.sv
// ----------------------------------------------------------------------------
// p4sd_pix_if
// Valid/ready channel that carries one decoded RGB565 pixel per beat.
// ----------------------------------------------------------------------------
interface p4sd_pix_if;

	logic                          valid;
	logic                          ready;
	logic [p4sd_pkg::COLOR_W-1:0]  pixel_color;
	logic                          last_of_byte;
	logic                          last_of_frame;

	modport source (output valid, output pixel_color, output last_of_byte,
		output last_of_frame, input ready);
	modport sink   (input valid, input pixel_color, input last_of_byte,
		input last_of_frame, output ready);

endinterface

// File: hdl/palette_4bpp_sprite_decoder.sv
// ----------------------------------------------------------------------------
// palette_4bpp_sprite_decoder
// Decodes a byte stream of 4bpp indexed sprite frames into RGB565 pixels.
// ----------------------------------------------------------------------------
//
//   channel  dir  beat                     payload
//   -------  ---  -----------------------  -----------------------------------
//   bytes    in   one frame byte           data_byte
//   pixels   out  one decoded pixel        pixel_color, last_of_byte,
//                                          last_of_frame
//   apb      in   register write or read   sprite_width, sprite_height
//
// The first 32 bytes of a frame write the palette, one entry per byte pair,
// high byte first. A pixel byte reads both palette entries in the cycle it
// is taken, passes through the read stage and the output stage, and leaves
// as two beats, or as one for the last byte of an odd-sized frame. Ready on
// bytes is low while the read stage is full, so no byte is taken while a
// pixel byte waits there. Reset clears the counters and sets both sides to
// 32; the palette is not cleared. A stall on pixels holds the output stage,
// then the read stage, and ready on bytes stays low until the read stage moves on.
// ----------------------------------------------------------------------------
module palette_4bpp_sprite_decoder #(
	parameter int MAX_SIDE = p4sd_pkg::MAX_SIDE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [p4sd_pkg::PADDR_W-1:0]      paddr,
	input  logic [p4sd_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [p4sd_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	p4sd_byte_if.sink                         bytes,
	p4sd_pix_if.source                        pixels
);

	localparam int CLAMP_W = $clog2(MAX_SIDE + 1);
	localparam int TOT_W   = $clog2(MAX_SIDE * MAX_SIDE + 1);
	localparam int BP_W    = $clog2(p4sd_pkg::PAL_BYTES + 1);

	// Configuration registers.
	logic [p4sd_pkg::SIDE_W-1:0]     width_q;
	logic [p4sd_pkg::SIDE_W-1:0]     height_q;
	logic                            cfg_we;
	p4sd_pkg::reg_idx_t              cfg_idx;

	// Frame counters.
	logic [BP_W-1:0]                 byte_pos_q;
	logic [TOT_W-1:0]                pix_cnt_q;
	logic [p4sd_pkg::DATA_W-1:0]     pal_hi_q;

	// Palette memory and its read stage.
	logic [p4sd_pkg::COLOR_W-1:0]    pal_mem [p4sd_pkg::PAL_ENTRIES];
	logic [p4sd_pkg::COLOR_W-1:0]    rd_hi_s1;
	logic [p4sd_pkg::COLOR_W-1:0]    rd_lo_s1;
	logic                            v_s1;
	logic                            two_s1;
	logic                            lof_s1;

	// Output stage.
	logic [p4sd_pkg::COLOR_W-1:0]    c0_q;
	logic [p4sd_pkg::COLOR_W-1:0]    c1_q;
	logic                            out_v_q;
	logic                            out_two_q;
	logic                            out_lof_q;
	logic                            out_idx_q;

	// Decode helpers.
	logic                            acc;
	logic                            pal_phase;
	logic                            pal_we;
	logic [p4sd_pkg::PAL_IDX_W-1:0]  pal_waddr;
	logic [CLAMP_W-1:0]              side_w;
	logic [CLAMP_W-1:0]              side_h;
	logic [TOT_W-1:0]                total;
	logic [TOT_W-1:0]                remaining;
	logic                            frame_over;
	logic                            rem_one;
	logic                            rem_two;
	logic                            pix_ok;
	logic                            last_pix;
	logic                            out_free;
	logic                            mv_s1;

	// Configuration port: writes complete without wait states, reads return the register.
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign cfg_idx = p4sd_pkg::reg_idx_t'(paddr[p4sd_pkg::PADDR_W-1]);

	always_comb begin
		unique case (cfg_idx)
			p4sd_pkg::REG_SPRITE_WIDTH:  prdata = p4sd_pkg::APB_DATA_W'(width_q);
			p4sd_pkg::REG_SPRITE_HEIGHT: prdata = p4sd_pkg::APB_DATA_W'(height_q);
			default:                     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= p4sd_pkg::SIDE_W'(p4sd_pkg::SIDE_RESET);
			height_q <= p4sd_pkg::SIDE_W'(p4sd_pkg::SIDE_RESET);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				p4sd_pkg::REG_SPRITE_WIDTH:  width_q <= pwdata[p4sd_pkg::SIDE_W-1:0];
				p4sd_pkg::REG_SPRITE_HEIGHT: height_q <= pwdata[p4sd_pkg::SIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp each side to 1..MAX_SIDE and form the pixel total.
	always_comb begin
		if (width_q == '0) begin
			side_w = CLAMP_W'(1);
		end else if (32'(width_q) > MAX_SIDE) begin
			side_w = CLAMP_W'(MAX_SIDE);
		end else begin
			side_w = CLAMP_W'(width_q);
		end
		if (height_q == '0) begin
			side_h = CLAMP_W'(1);
		end else if (32'(height_q) > MAX_SIDE) begin
			side_h = CLAMP_W'(MAX_SIDE);
		end else begin
			side_h = CLAMP_W'(height_q);
		end
	end

	assign total      = TOT_W'(side_w) * TOT_W'(side_h);
	assign remaining  = total - pix_cnt_q;
	assign frame_over = pix_cnt_q >= total;
	assign rem_one    = remaining == TOT_W'(1);
	assign rem_two    = remaining == TOT_W'(2);

	// Input decode.
	assign bytes.ready = !v_s1;
	assign acc         = bytes.valid && bytes.ready;
	assign pal_phase   = byte_pos_q < BP_W'(p4sd_pkg::PAL_BYTES);
	assign pal_we      = acc && pal_phase && byte_pos_q[0];
	assign pal_waddr   = byte_pos_q[p4sd_pkg::PAL_IDX_W:1];
	assign pix_ok      = acc && !pal_phase && !frame_over;

	// Frame counters: byte position stops at the end of the palette.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			pix_cnt_q  <= '0;
			pal_hi_q   <= '0;
		end else if (acc) begin
			if (pal_phase) begin
				if (!byte_pos_q[0]) begin
					pal_hi_q <= bytes.data_byte;
				end
				byte_pos_q <= byte_pos_q + BP_W'(1);
			end else if (frame_over || rem_one || rem_two) begin
				byte_pos_q <= '0;
				pix_cnt_q  <= '0;
				pal_hi_q   <= '0;
			end else begin
				pix_cnt_q <= pix_cnt_q + TOT_W'(2);
			end
		end
	end

	// Palette memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[pal_waddr] <= {pal_hi_q, bytes.data_byte};
		end
		if (pix_ok) begin
			rd_hi_s1 <= pal_mem[bytes.data_byte[p4sd_pkg::DATA_W-1:p4sd_pkg::NIBBLE_W]];
			rd_lo_s1 <= pal_mem[bytes.data_byte[p4sd_pkg::NIBBLE_W-1:0]];
		end
	end

	// Output stage handoff.
	assign last_pix = out_idx_q || !out_two_q;
	assign out_free = !out_v_q || (pixels.ready && last_pix);
	assign mv_s1    = v_s1 && out_free;

	// Read stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			two_s1 <= 1'b0;
			lof_s1 <= 1'b0;
		end else begin
			if (mv_s1) begin
				v_s1 <= 1'b0;
			end
			if (pix_ok) begin
				v_s1   <= 1'b1;
				two_s1 <= !rem_one;
				lof_s1 <= rem_one || rem_two;
			end
		end
	end

	// Output stage control: walks through one or two pixels of a byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			out_two_q <= 1'b0;
			out_lof_q <= 1'b0;
			out_idx_q <= 1'b0;
		end else if (mv_s1) begin
			out_v_q   <= 1'b1;
			out_two_q <= two_s1;
			out_lof_q <= lof_s1;
			out_idx_q <= 1'b0;
		end else if (pixels.valid && pixels.ready) begin
			if (last_pix) begin
				out_v_q <= 1'b0;
			end else begin
				out_idx_q <= 1'b1;
			end
		end
	end

	// Output stage colors.
	always_ff @(posedge clk) begin
		if (mv_s1) begin
			c0_q <= rd_hi_s1;
			c1_q <= rd_lo_s1;
		end
	end

	assign pixels.valid         = out_v_q;
	assign pixels.pixel_color   = out_idx_q ? c1_q : c0_q;
	assign pixels.last_of_byte  = last_pix;
	assign pixels.last_of_frame = out_lof_q && last_pix;

endmodule
